>>> rtl/core/sgprm_pkg.sv
// ----------------------------------------------------------------------------
// sgprm_pkg
// Shared types and constants for the stereo gain/pan ramp and peak meter core.
// ----------------------------------------------------------------------------
package sgprm_pkg;

  // sample and meter widths
  localparam int SAMPLE_BITS = 24;
  localparam int PEAK_W      = SAMPLE_BITS - 1;

  // configuration register widths
  localparam int VOL_W      = 18;
  localparam int PAN_W      = 16;
  localparam int LEN_W      = 13;
  localparam int DECAY_W    = 16;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  // ramp arithmetic: gain is unsigned Q2.28, step is signed Q2.28
  localparam int RAMP_EXTRA = 12;
  localparam int GAIN_W     = VOL_W + RAMP_EXTRA;
  localparam int STEP_W     = GAIN_W + 1;
  localparam int PROD_W     = SAMPLE_BITS + STEP_W;
  localparam int RND_SHIFT  = 28;
  localparam int DIV_CNT_W  = $clog2(GAIN_W + 1);

  localparam logic [VOL_W-1:0]   UNITY_GAIN    = 18'd65536;
  localparam logic [LEN_W-1:0]   BLOCK_RESET   = 13'd256;
  localparam logic [DECAY_W-1:0] DECAY_RESET   = 16'hFFFF;
  localparam logic [PEAK_W-1:0]  PEAK_KEEP_MIN = 23'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME = 2'd0,
    CFG_PAN    = 2'd1,
    CFG_BLOCK  = 2'd2,
    CFG_DECAY  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [PEAK_W-1:0]             meter_in_left;
    logic [PEAK_W-1:0]             meter_in_right;
    logic [PEAK_W-1:0]             meter_out_left;
    logic [PEAK_W-1:0]             meter_out_right;
    logic                          block_end;
  } out_item_t;

  // live configuration, block length already clamped to its legal range
  typedef struct packed {
    logic [VOL_W-1:0]        vol;
    logic signed [PAN_W-1:0] pan;
    logic [LEN_W-1:0]        len;
    logic [DECAY_W-1:0]      decay;
  } sgprm_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_RND,
    ST_FIN
  } sgprm_state_t;

  typedef struct packed {
    logic cap_in;   // latch input item
    logic prep;     // decay peaks, form start/end gains
    logic div_go;   // load ramp start, launch step dividers
    logic step_ld;  // take ramp steps from dividers
    logic mul;      // sample x gain
    logic rnd;      // round and saturate
    logic fin;      // meters, ramp advance, result register
  } sgprm_cmd_t;

  typedef struct packed {
    logic first_frame;
    logic div_busy;
  } sgprm_sts_t;

endpackage

>>> rtl/core/sgprm_div.sv
// ----------------------------------------------------------------------------
// sgprm_div
// Restoring divider, one quotient bit per cycle: ramp step = delta / length,
// truncated toward zero.
// ----------------------------------------------------------------------------
module sgprm_div
  import sgprm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [GAIN_W-1:0]        dividend,
  input  logic                     neg,
  input  logic [LEN_W-1:0]         divisor,
  output logic                     busy,
  output logic signed [STEP_W-1:0] quotient
);

  logic [GAIN_W-1:0]    quo_r, quo_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [LEN_W-1:0]     dvs_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [LEN_W:0]       shifted;
  logic [LEN_W:0]       trial;
  logic                 qbit;

  always_comb begin
    shifted = {rem_r, quo_r[GAIN_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    qbit    = (shifted >= {1'b0, dvs_r});
    rem_nxt = qbit ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
    quo_nxt = {quo_r[GAIN_W-2:0], qbit};
    cnt_nxt = cnt_r - DIV_CNT_W'(1);
    busy_nxt = (cnt_r != DIV_CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(GAIN_W);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= neg;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

>>> rtl/core/sgprm_ctrl.sv
// ----------------------------------------------------------------------------
// sgprm_ctrl
// Frame sequencer: accept, block-start preparation, scale, deliver.
// ----------------------------------------------------------------------------
module sgprm_ctrl
  import sgprm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sgprm_sts_t sts,
  output sgprm_cmd_t cmd
);

  sgprm_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = sts.first_frame ? ST_PREP : ST_MUL;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          cmd.step_ld = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // result register must be empty or emptying this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/sgprm_dpath.sv
// ----------------------------------------------------------------------------
// sgprm_dpath
// Gain ramp, sample scaling, peak meters and result register.
// ----------------------------------------------------------------------------
module sgprm_dpath
  import sgprm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sgprm_cmd_t cmd,
  input  sgprm_cfg_t cfg,
  input  in_item_t   in_data,
  output sgprm_sts_t sts,
  output out_item_t  out_data
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (RND_SHIFT - 1));
  localparam int SAT_W = PROD_W - RND_SHIFT;

  // Q2.16 channel gain, pan law applied to one side only, widened to Q2.28
  function automatic logic [GAIN_W-1:0] chan_gain(input logic [VOL_W-1:0]        vol,
                                                   input logic signed [PAN_W-1:0] pan,
                                                   input logic                    right);
    logic [PAN_W-1:0]       neg_pan;
    logic [PAN_W-2:0]       fac;
    logic [VOL_W+PAN_W-2:0] prod;
    logic                   use_pan;
    logic [VOL_W-1:0]       g;
    neg_pan = PAN_W'(0) - pan;
    fac     = right ? pan[PAN_W-2:0] : neg_pan[PAN_W-2:0];
    use_pan = right ? pan[PAN_W-1] : (!pan[PAN_W-1] && (pan != '0));
    prod    = vol * fac;
    g       = use_pan ? prod[VOL_W+PAN_W-2:PAN_W-1] : vol;
    return {g, RAMP_EXTRA'(0)};
  endfunction

  function automatic logic [PEAK_W-1:0] decay(input logic [PEAK_W-1:0]  pk,
                                               input logic [DECAY_W-1:0] dfac);
    logic [PEAK_W+DECAY_W-1:0] p;
    logic [PEAK_W-1:0]         d;
    p = pk * dfac;
    d = p[PEAK_W+DECAY_W-1:DECAY_W];
    return (d < PEAK_KEEP_MIN) ? '0 : d;
  endfunction

  function automatic logic [GAIN_W-1:0] ramp_adv(input logic [GAIN_W-1:0]        g,
                                                  input logic signed [STEP_W-1:0] s);
    logic signed [GAIN_W+1:0] sum;
    sum = $signed({2'b00, g}) + $signed({s[STEP_W-1], s});
    if (sum[GAIN_W+1])    return '0;
    else if (sum[GAIN_W]) return '1;
    else                  return sum[GAIN_W-1:0];
  endfunction

  // round half up to Q1.23, saturate
  function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic [SAT_W-1:0]         q;
    logic                     fits;
    s    = p + RND_HALF;
    q    = s[PROD_W-1:RND_SHIFT];
    fits = (q[SAT_W-1:SAMPLE_BITS-1] == '0) || (q[SAT_W-1:SAMPLE_BITS-1] == '1);
    if (fits)            return q[SAMPLE_BITS-1:0];
    else if (q[SAT_W-1]) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else                 return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  function automatic logic [PEAK_W-1:0] peak_upd(input logic signed [SAMPLE_BITS-1:0] x,
                                                  input logic [PEAK_W-1:0]             pk);
    return (!x[SAMPLE_BITS-1] && (x[PEAK_W-1:0] > pk)) ? x[PEAK_W-1:0] : pk;
  endfunction

  logic signed [SAMPLE_BITS-1:0] x_l_r, x_r_r;
  logic [GAIN_W-1:0]             gs_l_r, gs_r_r, ge_l_r, ge_r_r;
  logic [GAIN_W-1:0]             ramp_l_r, ramp_r_r;
  logic signed [STEP_W-1:0]      step_l_r, step_r_r;
  logic [VOL_W-1:0]              last_vol_r;
  logic signed [PAN_W-1:0]       last_pan_r;
  logic [PEAK_W-1:0]             pk_il_r, pk_ir_r, pk_ol_r, pk_or_r;
  logic [PEAK_W-1:0]             pk_il_nxt, pk_ir_nxt, pk_ol_nxt, pk_or_nxt;
  logic [LEN_W-1:0]              frame_r;
  logic signed [PROD_W-1:0]      prod_l_r, prod_r_r;
  logic signed [SAMPLE_BITS-1:0] y_l_r, y_r_r;
  out_item_t                     out_r;
  logic                          last;

  logic                     dneg_l, dneg_r, busy_l, busy_r;
  logic [GAIN_W-1:0]        dmag_l, dmag_r;
  logic signed [STEP_W-1:0] q_l, q_r;

  // ramp delta sign and magnitude for the step dividers
  always_comb begin
    dneg_l = (ge_l_r < gs_l_r);
    dneg_r = (ge_r_r < gs_r_r);
    dmag_l = dneg_l ? (gs_l_r - ge_l_r) : (ge_l_r - gs_l_r);
    dmag_r = dneg_r ? (gs_r_r - ge_r_r) : (ge_r_r - gs_r_r);
  end

  sgprm_div u_div_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dmag_l),
    .neg      (dneg_l),
    .divisor  (cfg.len),
    .busy     (busy_l),
    .quotient (q_l)
  );

  sgprm_div u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dmag_r),
    .neg      (dneg_r),
    .divisor  (cfg.len),
    .busy     (busy_r),
    .quotient (q_r)
  );

  always_comb begin
    pk_il_nxt = peak_upd(x_l_r, pk_il_r);
    pk_ir_nxt = peak_upd(x_r_r, pk_ir_r);
    pk_ol_nxt = peak_upd(y_l_r, pk_ol_r);
    pk_or_nxt = peak_upd(y_r_r, pk_or_r);
    last      = ({1'b0, frame_r} + (LEN_W + 1)'(1)) >= {1'b0, cfg.len};
  end

  // state with a defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_l_r   <= '0;
      ramp_r_r   <= '0;
      step_l_r   <= '0;
      step_r_r   <= '0;
      last_vol_r <= UNITY_GAIN;
      last_pan_r <= '0;
      pk_il_r    <= '0;
      pk_ir_r    <= '0;
      pk_ol_r    <= '0;
      pk_or_r    <= '0;
      frame_r    <= '0;
    end else begin
      if (cmd.prep) begin
        pk_il_r <= decay(pk_il_r, cfg.decay);
        pk_ir_r <= decay(pk_ir_r, cfg.decay);
        pk_ol_r <= decay(pk_ol_r, cfg.decay);
        pk_or_r <= decay(pk_or_r, cfg.decay);
      end
      if (cmd.div_go) begin
        ramp_l_r <= gs_l_r;
        ramp_r_r <= gs_r_r;
      end
      if (cmd.step_ld) begin
        step_l_r <= q_l;
        step_r_r <= q_r;
      end
      if (cmd.fin) begin
        pk_il_r  <= pk_il_nxt;
        pk_ir_r  <= pk_ir_nxt;
        pk_ol_r  <= pk_ol_nxt;
        pk_or_r  <= pk_or_nxt;
        ramp_l_r <= ramp_adv(ramp_l_r, step_l_r);
        ramp_r_r <= ramp_adv(ramp_r_r, step_r_r);
        if (last) begin
          last_vol_r <= cfg.vol;
          last_pan_r <= cfg.pan;
          frame_r    <= '0;
        end else begin
          frame_r <= frame_r + LEN_W'(1);
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      x_l_r <= in_data.left_in;
      x_r_r <= in_data.right_in;
    end
    if (cmd.prep) begin
      gs_l_r <= chan_gain(last_vol_r, last_pan_r, 1'b0);
      gs_r_r <= chan_gain(last_vol_r, last_pan_r, 1'b1);
      ge_l_r <= chan_gain(cfg.vol, cfg.pan, 1'b0);
      ge_r_r <= chan_gain(cfg.vol, cfg.pan, 1'b1);
    end
    if (cmd.mul) begin
      prod_l_r <= x_l_r * $signed({1'b0, ramp_l_r});
      prod_r_r <= x_r_r * $signed({1'b0, ramp_r_r});
    end
    if (cmd.rnd) begin
      y_l_r <= rnd_sat(prod_l_r);
      y_r_r <= rnd_sat(prod_r_r);
    end
    if (cmd.fin) begin
      out_r.left_out        <= y_l_r;
      out_r.right_out       <= y_r_r;
      out_r.meter_in_left   <= pk_il_nxt;
      out_r.meter_in_right  <= pk_ir_nxt;
      out_r.meter_out_left  <= pk_ol_nxt;
      out_r.meter_out_right <= pk_or_nxt;
      out_r.block_end       <= last;
    end
  end

  assign sts.first_frame = (frame_r == '0);
  assign sts.div_busy    = busy_l | busy_r;
  assign out_data        = out_r;

endmodule

>>> rtl/core/stereo_gain_pan_ramp_meter_core.sv
// ----------------------------------------------------------------------------
// stereo_gain_pan_ramp_meter_core
// Stereo volume/pan with a per-block linear gain ramp and four peak meters.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload               direction
//  -------  -------------------  --------------------  ---------
//  in       in_valid / in_stall  in_data (in_item_t)    into core
//  out      out_valid/out_stall  out_data (out_item_t)  out of core
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_wdata   into core
//
//  Sequence: an ordinary frame passes through accept/latch, multiply,
//  round/saturate and meter update; its result is offered once the meter
//  update step has registered it. Between accept and multiply, the first
//  frame of a block adds peak decay and gain formation, divider launch, two
//  restoring dividers (one per channel, one quotient bit per cycle over the
//  30-bit gain delta) and the step load. One item is in work at a time.
//  Reset: rst_n synchronous; registers back to their documented defaults,
//  ramp/meter state to zero, unity gain and centre pan remembered.
//  Stalls: the result register frees the input side, so a new item is taken
//  while a result waits; the core holds in its final step only if the
//  previous result still sits there unaccepted.
//  cfg_ready is always high; each write is registered directly into its register.
//
module stereo_gain_pan_ramp_meter_core
  import sgprm_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [VOL_W-1:0]        vol_r;
  logic signed [PAN_W-1:0] pan_r;
  logic [LEN_W-1:0]        blk_r;
  logic [DECAY_W-1:0]      decay_r;
  logic [LEN_W-1:0]        eff_len;
  sgprm_cfg_t              cfg;
  sgprm_cmd_t              cmd;
  sgprm_sts_t              sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r   <= UNITY_GAIN;
      pan_r   <= '0;
      blk_r   <= BLOCK_RESET;
      decay_r <= DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VOLUME: vol_r   <= cfg_wdata[VOL_W-1:0];
        CFG_PAN:    pan_r   <= cfg_wdata[PAN_W-1:0];
        CFG_BLOCK:  blk_r   <= cfg_wdata[LEN_W-1:0];
        CFG_DECAY:  decay_r <= cfg_wdata[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // block length: zero means one, anything above MAX_BLOCK is clipped
  always_comb begin
    if (blk_r == '0)
      eff_len = LEN_W'(1);
    else if (int'(blk_r) > MAX_BLOCK)
      eff_len = LEN_W'(MAX_BLOCK);
    else
      eff_len = blk_r;
  end

  assign cfg.vol   = vol_r;
  assign cfg.pan   = pan_r;
  assign cfg.len   = eff_len;
  assign cfg.decay = decay_r;

  sgprm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgprm_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/sgprm_chk.sv
// ----------------------------------------------------------------------------
// sgprm_chk
// Port-level checks for the stereo gain/pan ramp and peak meter core.
// ----------------------------------------------------------------------------
module sgprm_chk
  import sgprm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // no result left over from before reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item in work: input side closes right after an accept
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // and does not change under it
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

endmodule

bind stereo_gain_pan_ramp_meter_core sgprm_chk u_sgprm_chk (.*);

>>> verif/stereo_gain_pan_ramp_meter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_gain_pan_ramp_meter_core_tb
// Self-checking bench for the stereo gain/pan ramp and peak meter core.
// A short directed run covers the sample extremes, full pan both ways,
// saturation, block length zero and over-long, a length change inside a
// block and the peak floor. Random phases with fresh settings follow. A local
// predictor follows every accepted item, and each result is compared field by
// field against it. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module stereo_gain_pan_ramp_meter_core_tb;
  import sgprm_pkg::*;

  localparam int     MAX_LEN     = 4096;
  localparam int     ITEM_TARGET = 600;
  localparam longint RAMP_TOP    = 64'h3FFF_FFFF;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_WAIT  = 60;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stereo_gain_pan_ramp_meter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: live registers plus the core's ramp/meter state
  // --------------------------------------------------------------------------
  logic [VOL_W-1:0]        cur_vol   = UNITY_GAIN;
  logic signed [PAN_W-1:0] cur_pan   = '0;
  logic [LEN_W-1:0]        cur_len   = BLOCK_RESET;
  logic [DECAY_W-1:0]      cur_decay = DECAY_RESET;

  longint gain_l = 0, gain_r = 0;      // Q2.28, unsigned
  longint step_l = 0, step_r = 0;      // Q2.28, signed
  longint prev_vol = 65536, prev_pan = 0;
  longint pk_in_l = 0, pk_in_r = 0, pk_out_l = 0, pk_out_r = 0;
  longint frame_pos = 0;

  in_item_t  frames_to_send[$];
  out_item_t frames_due[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_cnt = 0;
  int  items_queued = 0;
  bit  calm = 1'b0;       // phase with no idling on either side
  bit  in_took = 1'b0;
  int  in_gap = 0;
  int  stall_left = 0;

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------

  // Channel gain in Q2.28: pan only ever attenuates the far side
  function automatic longint chan_gain(longint vol, longint pan, bit right);
    longint g;
    g = vol;
    if (!right && pan > 0)
      g = (g * (32768 - pan)) >>> 15;
    else if (right && pan < 0)
      g = (g * (32768 + pan)) >>> 15;
    return g <<< RAMP_EXTRA;
  endfunction

  function automatic longint ramp_next(longint g, longint s);
    longint v;
    v = g + s;
    if (v < 0) v = 0;
    if (v > RAMP_TOP) v = RAMP_TOP;
    return v;
  endfunction

  // sample x gain, round half up to Q1.23, saturate
  function automatic longint apply_gain(longint x, longint g);
    longint p;
    p = (x * g + (longint'(1) <<< 27)) >>> RND_SHIFT;
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p;
  endfunction

  function automatic longint decay_peak(longint p);
    longint v;
    v = (p * longint'(cur_decay)) >>> 16;
    return (v < 9) ? 0 : v;
  endfunction

  // One frame through the gain/pan/meter path; updates predictor state
  function automatic out_item_t gain_pan_frame(in_item_t it);
    longint len, end_l, end_r, xl, xr, yl, yr;
    out_item_t r;
    len = longint'(cur_len);
    if (len == 0) len = 1;
    if (len > MAX_LEN) len = MAX_LEN;
    if (frame_pos == 0) begin
      end_l    = chan_gain(longint'(cur_vol), longint'(cur_pan), 1'b0);
      end_r    = chan_gain(longint'(cur_vol), longint'(cur_pan), 1'b1);
      pk_in_l  = decay_peak(pk_in_l);
      pk_in_r  = decay_peak(pk_in_r);
      pk_out_l = decay_peak(pk_out_l);
      pk_out_r = decay_peak(pk_out_r);
      gain_l   = chan_gain(prev_vol, prev_pan, 1'b0);
      gain_r   = chan_gain(prev_vol, prev_pan, 1'b1);
      step_l   = (end_l - gain_l) / len;   // truncates toward zero
      step_r   = (end_r - gain_r) / len;
    end
    xl = longint'($signed(it.left_in));
    xr = longint'($signed(it.right_in));
    yl = apply_gain(xl, gain_l);
    yr = apply_gain(xr, gain_r);
    if (xl > pk_in_l) pk_in_l = xl;
    if (xr > pk_in_r) pk_in_r = xr;
    if (yl > pk_out_l) pk_out_l = yl;
    if (yr > pk_out_r) pk_out_r = yr;
    gain_l = ramp_next(gain_l, step_l);
    gain_r = ramp_next(gain_r, step_r);
    r.block_end = (frame_pos + 1 >= len);
    if (r.block_end) begin
      prev_vol  = longint'(cur_vol);
      prev_pan  = longint'(cur_pan);
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
    r.left_out        = yl[SAMPLE_BITS-1:0];
    r.right_out       = yr[SAMPLE_BITS-1:0];
    r.meter_in_left   = pk_in_l[PEAK_W-1:0];
    r.meter_in_right  = pk_in_r[PEAK_W-1:0];
    r.meter_out_left  = pk_out_l[PEAK_W-1:0];
    r.meter_out_right = pk_out_r[PEAK_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and comparison
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic compare_frame(out_item_t got, out_item_t exp);
    if (got.left_out !== exp.left_out)
      report_mismatch($sformatf("result %0d left_out got %0d expected %0d", results_seen,
                                $signed(got.left_out), $signed(exp.left_out)));
    if (got.right_out !== exp.right_out)
      report_mismatch($sformatf("result %0d right_out got %0d expected %0d", results_seen,
                                $signed(got.right_out), $signed(exp.right_out)));
    if (got.meter_in_left !== exp.meter_in_left)
      report_mismatch($sformatf("result %0d meter_in_left got %0d expected %0d",
                                results_seen, got.meter_in_left, exp.meter_in_left));
    if (got.meter_in_right !== exp.meter_in_right)
      report_mismatch($sformatf("result %0d meter_in_right got %0d expected %0d",
                                results_seen, got.meter_in_right, exp.meter_in_right));
    if (got.meter_out_left !== exp.meter_out_left)
      report_mismatch($sformatf("result %0d meter_out_left got %0d expected %0d",
                                results_seen, got.meter_out_left, exp.meter_out_left));
    if (got.meter_out_right !== exp.meter_out_right)
      report_mismatch($sformatf("result %0d meter_out_right got %0d expected %0d",
                                results_seen, got.meter_out_right, exp.meter_out_right));
    if (got.block_end !== exp.block_end)
      report_mismatch($sformatf("result %0d block_end got %b expected %b",
                                results_seen, got.block_end, exp.block_end));
  endtask

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: accept at posedge, next item set up at negedge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      frames_due.push_back(gain_pan_frame(in_data));
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (in_took || !in_valid) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (frames_to_send.size() > 0) begin
        in_data  <= frames_to_send.pop_front();
        in_valid <= 1'b1;
        in_gap = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and random back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0)
        report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                  results_seen));
      else
        compare_frame(out_data, frames_due.pop_front());
      results_seen++;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 2) == 0)
        stall_left = pick_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // register write; predictor takes the same value at the accepting edge
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_VOLUME: cur_vol   = val[VOL_W-1:0];
      CFG_PAN:    cur_pan   = val[PAN_W-1:0];
      CFG_BLOCK:  cur_len   = val[LEN_W-1:0];
      CFG_DECAY:  cur_decay = val[DECAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_frame(int l, int r);
    in_item_t it;
    it.left_in  = l[SAMPLE_BITS-1:0];
    it.right_in = r[SAMPLE_BITS-1:0];
    frames_to_send.push_back(it);
    items_queued++;
  endtask

  // every item gives exactly one result, so no extra settling is needed
  task automatic wait_idle();
    while (frames_to_send.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic int rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 8388607;
      1: v = -8388608;
      2: v = $urandom_range(0, 40);
      3: v = -$urandom_range(0, 40);
      default: v = $signed($urandom() << 8) >>> 8;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] v;
    int n;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unity gain, centre pan, short block: sample extremes pass straight
    write_reg(CFG_VOLUME, 18'd65536);
    write_reg(CFG_PAN, 18'd0);
    write_reg(CFG_BLOCK, 18'd4);
    write_reg(CFG_DECAY, 18'hFFFF);
    end_writes();
    queue_frame(8388607, 8388607);
    queue_frame(-8388608, -8388608);
    queue_frame(0, 0);
    queue_frame(8388607, -8388608);
    queue_frame(1, -1);
    wait_idle();

    // Full volume, hard right, one-frame blocks, instant decay: saturation
    write_reg(CFG_VOLUME, 18'h3FFFF);
    write_reg(CFG_PAN, 18'h07FFF);
    write_reg(CFG_BLOCK, 18'd1);
    write_reg(CFG_DECAY, 18'd0);
    end_writes();
    queue_frame(8388607, 8388607);
    queue_frame(-8388608, -8388608);
    queue_frame(4194304, -4194304);
    queue_frame(-1, 1);
    wait_idle();

    // Silence, hard left, block length zero acts as one
    write_reg(CFG_VOLUME, 18'd0);
    write_reg(CFG_PAN, 18'h08000);
    write_reg(CFG_BLOCK, 18'd0);
    write_reg(CFG_DECAY, 18'hFFFF);
    end_writes();
    queue_frame(8388607, -8388608);
    queue_frame(123456, 654321);
    queue_frame(-8388608, 8388607);
    wait_idle();

    // Over-long block (clamped), then shortened while the block is running
    write_reg(CFG_VOLUME, 18'd100000);
    write_reg(CFG_PAN, 18'd12345);
    write_reg(CFG_BLOCK, 18'd5000);
    end_writes();
    queue_frame(3000000, -3000000);
    queue_frame(-7000000, 7000000);
    queue_frame(5, 6);
    wait_idle();
    write_reg(CFG_BLOCK, 18'd2);
    end_writes();
    queue_frame(2000000, 2000000);
    queue_frame(-2000000, 1000000);
    queue_frame(77, -77);
    wait_idle();

    // Peak floor: clear the meters, leave small peaks, halve them once
    write_reg(CFG_BLOCK, 18'd1);
    write_reg(CFG_DECAY, 18'd0);
    end_writes();
    queue_frame(9, 18);
    wait_idle();
    write_reg(CFG_DECAY, 18'd32768);
    end_writes();
    queue_frame(0, 0);
    queue_frame(-5, -5);
    wait_idle();

    // Random phases, each with a fresh mix of settings
    while (items_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        v = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 5))
          0: v = 18'd0;
          1: v = 18'h3FFFF;
          2: v = 18'd65536;
          default: ;
        endcase
        write_reg(CFG_VOLUME, v);
      end
      if ($urandom_range(0, 9) < 7) begin
        v = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 5))
          0: v[15:0] = 16'h8000;
          1: v[15:0] = 16'h7FFF;
          2: v[15:0] = 16'h0000;
          default: ;
        endcase
        write_reg(CFG_PAN, v);
      end
      if ($urandom_range(0, 9) < 7) begin
        v = CFG_DATA_W'($urandom());    // bits above the length field are don't-care
        case ($urandom_range(0, 19))
          0:       v[12:0] = 13'd0;
          1:       v[12:0] = LEN_W'($urandom_range(4097, 8191));
          2, 3:    v[12:0] = LEN_W'($urandom_range(17, 300));
          default: v[12:0] = LEN_W'($urandom_range(1, 16));
        endcase
        write_reg(CFG_BLOCK, v);
      end
      if ($urandom_range(0, 9) < 7) begin
        v = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 5))
          0: v[15:0] = 16'd0;
          1: v[15:0] = 16'hFFFF;
          2: v[15:0] = DECAY_W'($urandom_range(1, 1000));
          default: ;
        endcase
        write_reg(CFG_DECAY, v);
      end
      end_writes();
      calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 60);
      repeat (n) queue_frame(rand_sample(), rand_sample());
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (frames_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frames_due.size()));

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
